/* hdl/afca_pkg.sv */
// shared types and constants for the antenna flag count accumulator
// no dependencies; imported by every module of the block
`default_nettype none

package afca_pkg;

    // default sizes, handed down through the top level parameters
    localparam int NUM_ANTENNAS_DEF = 256;
    localparam int WORD_BITS_DEF    = 64;
    localparam int COUNT_BITS_DEF   = 48;

    // fixed field widths of the stream payloads
    localparam int ANT_W   = 8;
    localparam int FLAG_W  = 64;
    localparam int NBITS_W = 7;
    localparam int OUT_W   = 48;

    // input tdata layout: antenna_a, antenna_b, flag_bits, bit_count, zero pad
    localparam int S_ANT_A_LSB = 0;
    localparam int S_ANT_B_LSB = S_ANT_A_LSB + ANT_W;
    localparam int S_FLAG_LSB  = S_ANT_B_LSB + ANT_W;
    localparam int S_NBITS_LSB = S_FLAG_LSB + FLAG_W;
    localparam int S_USED_W    = S_NBITS_LSB + NBITS_W;
    localparam int S_TDATA_W   = ((S_USED_W + 7) / 8) * 8;

    // result tdata layout: seen, auto_flagged, auto_total, cross_flagged,
    // cross_total, zero pad
    localparam int M_USED_W  = 1 + 4 * OUT_W;
    localparam int M_TDATA_W = ((M_USED_W + 7) / 8) * 8;

    // action codes carried on s_tuser
    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef logic [ANT_W-1:0]   ant_t;
    typedef logic [FLAG_W-1:0]  flag_word_t;
    typedef logic [NBITS_W-1:0] nbits_t;
    typedef logic [OUT_W-1:0]   out_cnt_t;

    // table port controls
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } tbl_ctrl_t;

endpackage

`default_nettype wire

/* hdl/afca_popcnt.sv */
// clamps the valid-bit count and counts the set bits among the valid ones
// depends on afca_pkg
`default_nettype none

module afca_popcnt #(
    parameter int WORD_BITS = afca_pkg::WORD_BITS_DEF
) (
    input  wire afca_pkg::flag_word_t flag_bits,
    input  wire afca_pkg::nbits_t     bit_count,
    output afca_pkg::nbits_t          nbits,
    output afca_pkg::nbits_t          flagged
);
    import afca_pkg::*;

    flag_word_t masked;
    logic [3:0] byte_cnt [FLAG_W/8];

    assign nbits = (bit_count > NBITS_W'(WORD_BITS)) ? NBITS_W'(WORD_BITS) : bit_count;

    always_comb begin
        for (int i = 0; i < FLAG_W; i++) begin
            masked[i] = flag_bits[i] & (NBITS_W'(i) < nbits);
        end
    end

    // per-byte counts, then a sum over the eight bytes
    always_comb begin
        flagged = '0;
        for (int j = 0; j < FLAG_W / 8; j++) begin
            byte_cnt[j] = '0;
            for (int k = 0; k < 8; k++) begin
                byte_cnt[j] = byte_cnt[j] + 4'(masked[8*j + k]);
            end
        end
        for (int j = 0; j < FLAG_W / 8; j++) begin
            flagged = flagged + NBITS_W'(byte_cnt[j]);
        end
    end

endmodule

`default_nettype wire

/* hdl/afca_table.sv */
// per-antenna counter table: one write port, one read port, registered read
// depends on afca_pkg
`default_nettype none

module afca_table #(
    parameter int DEPTH  = afca_pkg::NUM_ANTENNAS_DEF,
    parameter int DATA_W = 1 + 4 * afca_pkg::COUNT_BITS_DEF
) (
    input  wire                         aclk,
    input  wire afca_pkg::tbl_ctrl_t    ctrl,
    input  wire [$clog2(DEPTH)-1:0]     wr_addr,
    input  wire [DATA_W-1:0]            wr_data,
    input  wire [$clog2(DEPTH)-1:0]     rd_addr,
    output logic [DATA_W-1:0]           rd_data
);
    import afca_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* hdl/afca_sat_add.sv */
// saturating add of a small increment to a table counter
// depends on afca_pkg
`default_nettype none

module afca_sat_add #(
    parameter int CNT_W = afca_pkg::COUNT_BITS_DEF
) (
    input  wire [CNT_W-1:0]       acc,
    input  wire afca_pkg::nbits_t inc,
    output logic [CNT_W-1:0]      sum
);
    import afca_pkg::*;

    logic [CNT_W:0] ext;

    assign ext = {1'b0, acc} + (CNT_W + 1)'(inc);
    assign sum = ext[CNT_W] ? {CNT_W{1'b1}} : ext[CNT_W-1:0];

endmodule

`default_nettype wire

/* hdl/antenna_flag_count_accumulator.sv */
// per-antenna flag statistics; counters live in one table memory
// read request: the table entry is read on acceptance and registered out of the response
// slot; a result still waiting on m_tready holds the block in the response slot
// add request: an autocorrelation takes the UPD_A slot, a cross UPD_A then UPD_B (two
// table read-modify-write slots on the single write port); s_tready is low out of idle
// after reset a clearing pass zeroes the table, with s_tready low
// depends on afca_pkg, afca_popcnt, afca_sat_add, afca_table
`default_nettype none

module antenna_flag_count_accumulator #(
    parameter int NUM_ANTENNAS = afca_pkg::NUM_ANTENNAS_DEF,
    parameter int WORD_BITS    = afca_pkg::WORD_BITS_DEF,
    parameter int COUNT_BITS   = afca_pkg::COUNT_BITS_DEF
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    // antenna_a, antenna_b, flag_bits, bit_count
    input  wire [afca_pkg::S_TDATA_W-1:0]     s_tdata,
    // action
    input  wire                               s_tuser,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // seen, auto_flagged, auto_total, cross_flagged, cross_total
    output logic [afca_pkg::M_TDATA_W-1:0]    m_tdata
);
    import afca_pkg::*;

    localparam int AW = $clog2(NUM_ANTENNAS);
    localparam int CB = COUNT_BITS;
    localparam int EW = 1 + 4 * CB;
    // entry layout from the top: seen, auto flagged, auto total, cross flagged, cross total
    localparam int CT_LSB   = 0;
    localparam int CF_LSB   = CB;
    localparam int AT_LSB   = 2 * CB;
    localparam int AF_LSB   = 3 * CB;
    localparam int SEEN_BIT = 4 * CB;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPD_A,
        ST_UPD_B,
        ST_RESP
    } state_t;

    state_t               state_reg;
    logic [AW-1:0]        clr_idx_reg;
    logic [AW-1:0]        a_idx_reg;
    logic [AW-1:0]        b_idx_reg;
    logic                 auto_reg;
    logic                 oor_reg;
    nbits_t               nbits_reg;
    nbits_t               flagged_reg;
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    ant_t       in_ant_a;
    ant_t       in_ant_b;
    flag_word_t in_flags;
    nbits_t     in_nbits;
    nbits_t     pc_nbits;
    nbits_t     pc_flagged;
    logic       a_oor;
    logic       b_oor;
    logic       accept;

    tbl_ctrl_t     tbl_ctrl;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [EW-1:0] wr_data;
    logic [EW-1:0] rd_data;
    logic [EW-1:0] upd_entry;
    logic [CB-1:0] acc_flag;
    logic [CB-1:0] acc_total;
    logic [CB-1:0] sum_flag;
    logic [CB-1:0] sum_total;
    logic          out_free;

    assign in_ant_a = s_tdata[S_ANT_A_LSB +: ANT_W];
    assign in_ant_b = s_tdata[S_ANT_B_LSB +: ANT_W];
    assign in_flags = s_tdata[S_FLAG_LSB +: FLAG_W];
    assign in_nbits = s_tdata[S_NBITS_LSB +: NBITS_W];

    assign a_oor    = 32'(in_ant_a) >= NUM_ANTENNAS;
    assign b_oor    = 32'(in_ant_b) >= NUM_ANTENNAS;
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid & s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    afca_popcnt #(
        .WORD_BITS (WORD_BITS)
    ) u_popcnt (
        .flag_bits (in_flags),
        .bit_count (in_nbits),
        .nbits     (pc_nbits),
        .flagged   (pc_flagged)
    );

    // first write slot of an autocorrelation hits the auto counters
    assign acc_flag  = (state_reg == ST_UPD_A && auto_reg) ? rd_data[AF_LSB +: CB]
                                                            : rd_data[CF_LSB +: CB];
    assign acc_total = (state_reg == ST_UPD_A && auto_reg) ? rd_data[AT_LSB +: CB]
                                                            : rd_data[CT_LSB +: CB];

    afca_sat_add #(
        .CNT_W (CB)
    ) u_sat_flag (
        .acc (acc_flag),
        .inc (flagged_reg),
        .sum (sum_flag)
    );

    afca_sat_add #(
        .CNT_W (CB)
    ) u_sat_total (
        .acc (acc_total),
        .inc (nbits_reg),
        .sum (sum_total)
    );

    always_comb begin
        upd_entry           = rd_data;
        upd_entry[SEEN_BIT] = 1'b1;
        if (state_reg == ST_UPD_A && auto_reg) begin
            upd_entry[AF_LSB +: CB] = sum_flag;
            upd_entry[AT_LSB +: CB] = sum_total;
        end else begin
            upd_entry[CF_LSB +: CB] = sum_flag;
            upd_entry[CT_LSB +: CB] = sum_total;
        end
    end

    // table port control
    always_comb begin
        tbl_ctrl = '0;
        wr_addr  = a_idx_reg;
        wr_data  = upd_entry;
        rd_addr  = AW'(in_ant_a);
        unique case (state_reg)
            ST_CLEAR: begin
                tbl_ctrl.wr_en = 1'b1;
                wr_addr        = clr_idx_reg;
                wr_data        = '0;
            end
            ST_IDLE: begin
                tbl_ctrl.rd_en = accept && !a_oor && (s_tuser == ACT_READ || !b_oor);
            end
            ST_UPD_A: begin
                tbl_ctrl.wr_en = 1'b1;
                tbl_ctrl.rd_en = !auto_reg;
                rd_addr        = b_idx_reg;
            end
            ST_UPD_B: begin
                tbl_ctrl.wr_en = 1'b1;
                wr_addr        = b_idx_reg;
            end
            ST_RESP: begin
                tbl_ctrl = '0;
            end
            default: begin
                tbl_ctrl = '0;
            end
        endcase
    end

    afca_table #(
        .DEPTH  (NUM_ANTENNAS),
        .DATA_W (EW)
    ) u_table (
        .aclk    (aclk),
        .ctrl    (tbl_ctrl),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_idx_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // the response slot drives the valid flag itself
            if (m_tvalid_reg && m_tready && state_reg != ST_RESP) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_idx_reg <= clr_idx_reg + 1'b1;
                    if (clr_idx_reg == AW'(NUM_ANTENNAS - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        a_idx_reg   <= AW'(in_ant_a);
                        b_idx_reg   <= AW'(in_ant_b);
                        auto_reg    <= (in_ant_a == in_ant_b);
                        oor_reg     <= a_oor;
                        nbits_reg   <= pc_nbits;
                        flagged_reg <= pc_flagged;
                        if (s_tuser == ACT_READ) begin
                            state_reg <= ST_RESP;
                        end else if (!a_oor && !b_oor) begin
                            state_reg <= ST_UPD_A;
                        end
                    end
                end
                ST_UPD_A: begin
                    state_reg <= auto_reg ? ST_IDLE : ST_UPD_B;
                end
                ST_UPD_B: begin
                    state_reg <= ST_IDLE;
                end
                ST_RESP: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        if (oor_reg) begin
                            m_tdata_reg <= '0;
                        end else begin
                            m_tdata_reg <= {{(M_TDATA_W - M_USED_W){1'b0}},
                                            OUT_W'(rd_data[CT_LSB +: CB]),
                                            OUT_W'(rd_data[CF_LSB +: CB]),
                                            OUT_W'(rd_data[AT_LSB +: CB]),
                                            OUT_W'(rd_data[AF_LSB +: CB]),
                                            rd_data[SEEN_BIT]};
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // a cross update writes one antenna while reading the other
    assert property (@(posedge aclk) disable iff (!aresetn)
        (tbl_ctrl.wr_en && tbl_ctrl.rd_en) |-> (wr_addr != rd_addr))
        else $error("table write and read collide on one entry");

    // no request is taken while the clearing pass runs
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("request accepted during table clear");

    // a result only appears out of the response slot
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == ST_RESP))
        else $error("result raised outside response state");

    // an accepted read request always heads for a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tuser == ACT_READ) |=> (state_reg == ST_RESP))
        else $error("read request lost");

endmodule

`default_nettype wire

/* tb/tb_antenna_flag_count_accumulator.sv */
// self-checking testbench for antenna_flag_count_accumulator
// keeps its own per-antenna flag tables and checks every read result against them
// depends on afca_pkg and the antenna_flag_count_accumulator rtl
`timescale 1ns / 1ps

module tb_antenna_flag_count_accumulator;

    import afca_pkg::*;

    localparam int N_ANT      = NUM_ANTENNAS_DEF;
    localparam int WORD_LIMIT = WORD_BITS_DEF;
    localparam int CNT_W      = COUNT_BITS_DEF;
    localparam int MAX_WAIT   = 8;
    localparam int TAIL_CYCLES = 20;
    localparam int CYCLE_LIMIT = 300000;
    localparam int RANDOM_REQS = 800;

    typedef logic [CNT_W-1:0] cnt_t;

    typedef struct {
        logic       action;
        ant_t       ant_a;
        ant_t       ant_b;
        flag_word_t flags;
        nbits_t     nbits;
        bit         drain_before;
    } antenna_req_t;

    typedef struct {
        logic     seen;
        out_cnt_t auto_flagged;
        out_cnt_t auto_total;
        out_cnt_t cross_flagged;
        out_cnt_t cross_total;
    } antenna_stats_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tuser = ACT_ADD;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    antenna_req_t   req_q[$];
    antenna_stats_t expected_stats_q[$];

    // predicted flag tables
    cnt_t auto_flag_tbl[N_ANT];
    cnt_t auto_total_tbl[N_ANT];
    cnt_t cross_flag_tbl[N_ANT];
    cnt_t cross_total_tbl[N_ANT];
    logic seen_tbl[N_ANT];

    int  error_count = 0;
    int  cycle_count = 0;
    int  send_hold = 0;
    int  recv_hold = 0;
    bit  send_calm = 1'b0;
    bit  recv_calm = 1'b0;

    antenna_flag_count_accumulator DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic int draw_wait(input bit calm);
        return calm ? 0 : int'($urandom_range(0, MAX_WAIT));
    endfunction

    function automatic cnt_t sat_inc(input cnt_t acc, input logic [6:0] inc);
        logic [CNT_W:0] sum;
        sum = {1'b0, acc} + inc;
        return sum[CNT_W] ? '1 : sum[CNT_W-1:0];
    endfunction

    // update the tables for an add, queue the expected stats for a read
    function automatic void absorb_request(input logic act, input logic [S_TDATA_W-1:0] d);
        ant_t           a, b;
        flag_word_t     word;
        int             valid_bits;
        logic [6:0]     flagged;
        antenna_stats_t stats;
        a = d[S_ANT_A_LSB +: ANT_W];
        b = d[S_ANT_B_LSB +: ANT_W];
        word = d[S_FLAG_LSB +: FLAG_W];
        valid_bits = int'(d[S_NBITS_LSB +: NBITS_W]);
        if (act == ACT_READ) begin
            stats.seen          = seen_tbl[a];
            stats.auto_flagged  = out_cnt_t'(auto_flag_tbl[a]);
            stats.auto_total    = out_cnt_t'(auto_total_tbl[a]);
            stats.cross_flagged = out_cnt_t'(cross_flag_tbl[a]);
            stats.cross_total   = out_cnt_t'(cross_total_tbl[a]);
            expected_stats_q.push_back(stats);
            return;
        end
        // counts past the word width are clipped
        if (valid_bits > WORD_LIMIT)
            valid_bits = WORD_LIMIT;
        flagged = '0;
        for (int i = 0; i < valid_bits; i++)
            flagged += word[i];
        if (a == b) begin
            auto_flag_tbl[a]  = sat_inc(auto_flag_tbl[a], flagged);
            auto_total_tbl[a] = sat_inc(auto_total_tbl[a], 7'(valid_bits));
            seen_tbl[a] = 1'b1;
        end else begin
            cross_flag_tbl[a]  = sat_inc(cross_flag_tbl[a], flagged);
            cross_total_tbl[a] = sat_inc(cross_total_tbl[a], 7'(valid_bits));
            cross_flag_tbl[b]  = sat_inc(cross_flag_tbl[b], flagged);
            cross_total_tbl[b] = sat_inc(cross_total_tbl[b], 7'(valid_bits));
            seen_tbl[a] = 1'b1;
            seen_tbl[b] = 1'b1;
        end
    endfunction

    function automatic void check_field(input string name, input out_cnt_t want,
                                        input out_cnt_t got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    function automatic void push_req(input logic act, input ant_t a, input ant_t b,
                                     input flag_word_t f, input nbits_t n,
                                     input bit drain);
        antenna_req_t r;
        r.action = act;
        r.ant_a = a;
        r.ant_b = b;
        r.flags = f;
        r.nbits = n;
        r.drain_before = drain;
        req_q.push_back(r);
    endfunction

    initial begin
        for (int i = 0; i < N_ANT; i++) begin
            auto_flag_tbl[i] = '0;
            auto_total_tbl[i] = '0;
            cross_flag_tbl[i] = '0;
            cross_total_tbl[i] = '0;
            seen_tbl[i] = 1'b0;
        end
    end

    // driver
    always @(posedge aclk) begin
        antenna_req_t r;
        bit           busy;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_hold = 0;
        end else begin
            busy = s_tvalid && !s_tready;
            if (!busy) begin
                if (send_hold != 0) begin
                    send_hold--;
                    s_tvalid <= 1'b0;
                end else if (req_q.size() != 0 &&
                             !(req_q[0].drain_before &&
                               (expected_stats_q.size() != 0 || s_tvalid))) begin
                    r = req_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= r.action;
                    s_tdata <= {{(S_TDATA_W - S_USED_W){1'b0}}, r.nbits, r.flags,
                                r.ant_b, r.ant_a};
                    if ($urandom_range(0, 39) == 0)
                        send_calm = !send_calm;
                    send_hold = draw_wait(send_calm);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: predicts on accepted requests, then checks accepted results
    always @(posedge aclk) begin
        antenna_stats_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_hold = 0;
        end else begin
            if (s_tvalid && s_tready)
                absorb_request(s_tuser, s_tdata);
            if (m_tvalid && m_tready) begin
                if (expected_stats_q.size() == 0) begin
                    $error("result with no read request waiting");
                    error_count++;
                end else begin
                    want = expected_stats_q.pop_front();
                    check_field("seen", out_cnt_t'(want.seen), out_cnt_t'(m_tdata[0]));
                    check_field("auto_flagged", want.auto_flagged, m_tdata[1 +: OUT_W]);
                    check_field("auto_total", want.auto_total, m_tdata[1 + OUT_W +: OUT_W]);
                    check_field("cross_flagged", want.cross_flagged,
                                m_tdata[1 + 2 * OUT_W +: OUT_W]);
                    check_field("cross_total", want.cross_total,
                                m_tdata[1 + 3 * OUT_W +: OUT_W]);
                    check_field("pad", '0, out_cnt_t'(m_tdata[M_TDATA_W-1:M_USED_W]));
                end
                if ($urandom_range(0, 39) == 0)
                    recv_calm = !recv_calm;
                recv_hold = draw_wait(recv_calm);
            end else if (recv_hold != 0) begin
                recv_hold--;
            end
            m_tready <= (recv_hold == 0);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("antenna_flag_count_accumulator test failed");
            $finish;
        end
    end

    initial begin
        ant_t       a, b;
        flag_word_t f;
        nbits_t     n;
        logic       act;
        int         pick;

        // directed: unseen reads, full and clipped counts, zero count, auto vs cross
        push_req(ACT_READ, 8'd0, 8'd0, '0, '0, 1'b0);
        push_req(ACT_READ, 8'd255, 8'd0, '1, '1, 1'b0);
        push_req(ACT_ADD, 8'd0, 8'd0, '1, 7'd64, 1'b0);
        push_req(ACT_ADD, 8'd0, 8'd0, '1, 7'd127, 1'b0);
        push_req(ACT_ADD, 8'd0, 8'd0, 64'h8000_0000_0000_0001, 7'd65, 1'b0);
        push_req(ACT_ADD, 8'd0, 8'd255, '1, 7'd0, 1'b0);
        push_req(ACT_ADD, 8'd255, 8'd1, '0, 7'd64, 1'b0);
        push_req(ACT_ADD, 8'd1, 8'd2, 64'hAAAA_AAAA_AAAA_AAAA, 7'd33, 1'b0);
        push_req(ACT_ADD, 8'd2, 8'd1, 64'h5555_5555_5555_5555, 7'd1, 1'b0);
        push_req(ACT_ADD, 8'd255, 8'd255, '1, 7'd1, 1'b0);
        push_req(ACT_ADD, 8'd7, 8'd7, '1, 7'd0, 1'b0);
        push_req(ACT_ADD, 8'd128, 8'd127, 64'hFFFF_0000_FFFF_0000, 7'd63, 1'b0);
        push_req(ACT_READ, 8'd0, 8'd255, '1, 7'd127, 1'b0);
        push_req(ACT_READ, 8'd255, 8'd0, '0, 7'd0, 1'b0);
        push_req(ACT_READ, 8'd1, 8'd1, '1, 7'd64, 1'b0);
        push_req(ACT_READ, 8'd2, 8'd3, '0, 7'd5, 1'b0);
        push_req(ACT_READ, 8'd7, 8'd7, '0, 7'd0, 1'b0);
        push_req(ACT_READ, 8'd128, 8'd0, '0, 7'd0, 1'b0);
        push_req(ACT_READ, 8'd127, 8'd0, '0, 7'd0, 1'b0);
        push_req(ACT_READ, 8'd3, 8'd170, 64'h0123_4567_89AB_CDEF, 7'd85, 1'b0);

        // random: hot antennas build up counts, a few full-range ones spread out
        for (int i = 0; i < RANDOM_REQS; i++) begin
            pick = $urandom_range(0, 99);
            a = ($urandom_range(0, 3) == 0) ? ant_t'($urandom_range(0, 255))
                                            : ant_t'($urandom_range(0, 7));
            b = ($urandom_range(0, 3) == 0) ? ant_t'($urandom_range(0, 255))
                                            : ant_t'($urandom_range(0, 7));
            f = {$urandom, $urandom};
            n = nbits_t'($urandom_range(0, 127));
            act = (pick < 30) ? ACT_READ : ACT_ADD;
            if (act == ACT_ADD) begin
                if (pick < 50)
                    b = a;
                case ($urandom_range(0, 7))
                    0: n = 7'd0;
                    1: n = 7'd64;
                    2: n = nbits_t'($urandom_range(65, 127));
                    default: n = nbits_t'($urandom_range(0, 64));
                endcase
                case ($urandom_range(0, 7))
                    0: f = '1;
                    1: f = '0;
                    default: ;
                endcase
            end
            push_req(act, a, b, f, n, (i % 200) == 100);
        end

        while (req_q.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (expected_stats_q.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("antenna_flag_count_accumulator test passed");
        else
            $display("antenna_flag_count_accumulator test failed");
        $finish;
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
    end

endmodule

/* files.f */
hdl/afca_pkg.sv
hdl/afca_popcnt.sv
hdl/afca_table.sv
hdl/afca_sat_add.sv
hdl/antenna_flag_count_accumulator.sv
tb/tb_antenna_flag_count_accumulator.sv
